// ===== hw/rtl/bppu_pkg.sv =====
package bppu_pkg;

    localparam int BUFFER_WORDS_DEF = 64;
    localparam int WORD_BITS = 32;
    localparam int LEN_W = 6;
    localparam int BIT_W = 5;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_NOP,
        OP_DROP
    } op_kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_WRITE_LO
    } back_state_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [BIT_W-1:0]       bit_pos;
        logic [LEN_W-1:0]       len;
        logic [WORD_BITS-1:0]   value;
    } queue_op_t;

    function automatic logic [WORD_BITS-1:0] low_mask(input logic [LEN_W-1:0] len);
        return {WORD_BITS{1'b1}} >> (LEN_W'(WORD_BITS) - len);
    endfunction

endpackage

// ===== hw/rtl/bppu_front.sv =====
module bppu_front #(
    parameter int BUFFER_WORDS = bppu_pkg::BUFFER_WORDS_DEF,
    parameter int AW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  cmd,
    input  logic [31:0]           value,
    input  logic [5:0]            length,
    output logic                  push,
    output bppu_pkg::queue_op_t   push_op,
    output logic [AW-1:0]         push_word
);

    localparam int CAP = BUFFER_WORDS * bppu_pkg::WORD_BITS;
    localparam int PW = $clog2(CAP + 1);

    logic [PW-1:0]          wr_pos_reg, wr_pos_next;
    logic [PW-1:0]          rd_pos_reg, rd_pos_next;
    logic [5:0]             len_sat;
    logic [PW-1:0]          pos_sel;
    logic [PW:0]            end_pos;
    logic                   fits;
    bppu_pkg::op_kind_t     kind;

    always_comb
    begin
        len_sat = (length > 6'd32) ? 6'd32 : length;
        pos_sel = cmd ? rd_pos_reg : wr_pos_reg;
        end_pos = {1'b0, pos_sel} + (PW+1)'(len_sat);
        fits    = end_pos <= (PW+1)'(CAP);

        if (len_sat == 6'd0)
            kind = bppu_pkg::OP_NOP;
        else if (!fits)
            kind = bppu_pkg::OP_DROP;
        else if (cmd)
            kind = bppu_pkg::OP_READ;
        else
            kind = bppu_pkg::OP_WRITE;

        wr_pos_next = wr_pos_reg;
        rd_pos_next = rd_pos_reg;
        if (accept && kind == bppu_pkg::OP_WRITE)
            wr_pos_next = end_pos[PW-1:0];
        if (accept && kind == bppu_pkg::OP_READ)
            rd_pos_next = end_pos[PW-1:0];

        push              = accept;
        push_op.kind      = kind;
        push_op.bit_pos   = pos_sel[4:0];
        push_op.len       = len_sat;
        push_op.value     = value & bppu_pkg::low_mask(len_sat);
        push_word         = pos_sel[AW+4:5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg <= '0;
            rd_pos_reg <= '0;
        end
        else
        begin
            wr_pos_reg <= wr_pos_next;
            rd_pos_reg <= rd_pos_next;
        end
    end

endmodule

// ===== hw/rtl/bppu_queue.sv =====
module bppu_queue #(
    parameter int AW = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bppu_pkg::queue_op_t   push_op,
    input  logic [AW-1:0]         push_word,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output bppu_pkg::queue_op_t   head_op,
    output logic [AW-1:0]         head_word
);

    bppu_pkg::queue_op_t    op_reg [2];
    logic [AW-1:0]          word_reg [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign empty     = count_reg == 2'd0;
    assign head_op   = op_reg[rd_ptr_reg];
    assign head_word = word_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wr_ptr_reg]   <= push_op;
            word_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== hw/rtl/bppu_back.sv =====
module bppu_back #(
    parameter int BUFFER_WORDS = bppu_pkg::BUFFER_WORDS_DEF,
    parameter int AW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  bppu_pkg::queue_op_t   head_op,
    input  logic [AW-1:0]         head_word,
    output logic                  pop,
    output logic                  clear_busy,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic                  m_tuser
);

    logic [31:0]            mem [BUFFER_WORDS];

    bppu_pkg::back_state_t  state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    bppu_pkg::queue_op_t    cur_op_reg;
    logic [AW-1:0]          cur_word_reg;
    logic [31:0]            lo_word_reg;
    logic [31:0]            rd_hi_reg, rd_lo_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_data_reg;
    logic                   out_status_reg;

    logic                   slot_free;
    logic                   rd_en;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [31:0]            wr_data;
    logic                   load_out;
    logic [31:0]            out_data;
    logic                   out_status;
    logic                   load_lo;
    logic [6:0]             shift_full;
    logic [5:0]             shift;
    logic [6:0]             bit_end;
    logic                   straddle;
    logic [63:0]            win_sh;
    logic [63:0]            field;

    assign slot_free  = !out_valid_reg || m_tready;
    assign clear_busy = state_reg == bppu_pkg::ST_CLEAR;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser    = out_status_reg;

    always_comb
    begin
        shift_full = 7'd64 - 7'(cur_op_reg.bit_pos) - 7'(cur_op_reg.len);
        shift      = shift_full[5:0];
        bit_end    = 7'(cur_op_reg.bit_pos) + 7'(cur_op_reg.len);
        straddle   = bit_end > 7'd32;
        win_sh     = {rd_hi_reg, rd_lo_reg} >> shift;
        field      = {32'd0, cur_op_reg.value} << shift;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        pop           = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = cur_word_reg;
        wr_data       = '0;
        load_out      = 1'b0;
        out_data      = '0;
        out_status    = 1'b0;
        load_lo       = 1'b0;

        unique case (state_reg)
            bppu_pkg::ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(BUFFER_WORDS - 1))
                    state_next = bppu_pkg::ST_IDLE;
            end
            bppu_pkg::ST_IDLE:
            begin
                if (!q_empty && slot_free)
                begin
                    pop = 1'b1;
                    unique case (head_op.kind) inside
                        bppu_pkg::OP_NOP:
                        begin
                            load_out = 1'b1;
                        end
                        bppu_pkg::OP_DROP:
                        begin
                            load_out   = 1'b1;
                            out_status = 1'b1;
                        end
                        bppu_pkg::OP_WRITE, bppu_pkg::OP_READ:
                        begin
                            rd_en      = 1'b1;
                            state_next = bppu_pkg::ST_ACCESS;
                        end
                        default:
                        begin
                            state_next = bppu_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bppu_pkg::ST_ACCESS:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = bppu_pkg::ST_IDLE;
                    if (cur_op_reg.kind == bppu_pkg::OP_READ)
                    begin
                        out_data = win_sh[31:0] & bppu_pkg::low_mask(cur_op_reg.len);
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_hi_reg | field[63:32];
                        load_lo = 1'b1;
                        if (straddle)
                            state_next = bppu_pkg::ST_WRITE_LO;
                    end
                end
            end
            bppu_pkg::ST_WRITE_LO:
            begin
                wr_en      = 1'b1;
                wr_addr    = cur_word_reg + 1'b1;
                wr_data    = lo_word_reg;
                state_next = bppu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bppu_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bppu_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_op_reg   <= head_op;
            cur_word_reg <= head_word;
        end
        if (load_lo)
            lo_word_reg <= rd_lo_reg | field[31:0];
        if (load_out)
        begin
            out_data_reg   <= out_data;
            out_status_reg <= out_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_hi_reg <= mem[head_word];
            rd_lo_reg <= mem[head_word + 1'b1];
        end
    end

endmodule

// ===== hw/rtl/bitstream_packer_unpacker_unit.sv =====
// channel  dir  tdata (low bit up)              tuser
// s_*      in   value[31:0], length[37:32]      cmd (0 append, 1 extract)
// m_*      out  read_data[31:0]                 status (1 dropped)
//
// After reset a clearing pass zeroes the word store, one word a cycle;
// s_tready stays low until it ends. The word store has one write port, so
// a back-end transaction uses the idle state alone for zero-length or
// dropped items, idle then access for extracts and for appends inside one
// word, plus write-lo for appends straddling two words (write to next word).
// A two-entry queue separates the classifier from the store; s_tready drops
// only when it is full or clearing, and m_tready stalls only the store side.
module bitstream_packer_unpacker_unit #(
    parameter int BUFFER_WORDS = bppu_pkg::BUFFER_WORDS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // value[31:0], length[37:32], zero pad
    input  logic         s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // read_data[31:0]
    output logic         m_tuser    // status
);

    localparam int AW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;

    logic                   accept;
    logic                   push;
    bppu_pkg::queue_op_t    push_op;
    logic [AW-1:0]          push_word;
    logic                   pop;
    logic                   q_full;
    logic                   q_empty;
    bppu_pkg::queue_op_t    head_op;
    logic [AW-1:0]          head_word;
    logic                   clear_busy;

    assign s_tready = !q_full && !clear_busy;
    assign accept   = s_tvalid && s_tready;

    bppu_front #(
        .BUFFER_WORDS (BUFFER_WORDS),
        .AW           (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (s_tuser),
        .value     (s_tdata[31:0]),
        .length    (s_tdata[37:32]),
        .push      (push),
        .push_op   (push_op),
        .push_word (push_word)
    );

    bppu_queue #(
        .AW (AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .push_word (push_word),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head_op   (head_op),
        .head_word (head_word)
    );

    bppu_back #(
        .BUFFER_WORDS (BUFFER_WORDS),
        .AW           (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head_op    (head_op),
        .head_word  (head_word),
        .pop        (pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !s_tready)
        else $error("input accepted during clearing pass");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("queue popped while empty");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'd0))
        else $error("dropped transaction carries nonzero data");

endmodule
